>>> rtl/gcss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcss_pkg;

  // Default number of slots in each table.
  localparam int unsigned TABLE_DEPTH = 256;

  // Entries held between the front end and the search engine.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned GLYPH_W   = 16;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned FMT_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  // Range coverage index: start index plus offset, kept without wrap.
  localparam int unsigned CIDX_W    = GLYPH_W + 1;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_COV_WR = 2'd0;
  localparam logic [1:0] OP_SUB_WR = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COV_FMT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COV_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_FMT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_COUNT = 3'd4;

  // Format codes.
  localparam logic [FMT_W-1:0] COV_FMT_LIST  = 2'd1;
  localparam logic [FMT_W-1:0] COV_FMT_RANGE = 2'd2;
  localparam logic [FMT_W-1:0] SUB_FMT_DELTA = 2'd1;
  localparam logic [FMT_W-1:0] SUB_FMT_ARRAY = 2'd2;

  typedef struct packed {
    logic [FMT_W-1:0]   cov_fmt;
    logic [COUNT_W-1:0] cov_count;
    logic [FMT_W-1:0]   sub_fmt;
    logic [GLYPH_W-1:0] delta;
    logic [COUNT_W-1:0] sub_count;
  } cfg_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] first;
    logic [GLYPH_W-1:0] last;
    logic [GLYPH_W-1:0] start_index;
  } cov_entry_t;

  typedef enum logic [1:0] {
    CMD_COV_WR,
    CMD_SUB_WR,
    CMD_LOOKUP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [SLOT_W-1:0]  slot;
    cov_entry_t         entry;
    logic [GLYPH_W-1:0] sub_value;
    logic [GLYPH_W-1:0] glyph;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/gcss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gcss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/gcss_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gcss_front #(
  parameter int unsigned TABLE_DEPTH = gcss_pkg::TABLE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [gcss_pkg::SLOT_W-1:0]  entry_index_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0] entry_first_glyph_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0] entry_last_glyph_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0] entry_start_index_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0] substitute_value_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0] lookup_glyph_i,
  output logic                              cmd_valid_o,
  output gcss_pkg::cmd_t                    cmd_o,
  input  wire logic                         cmd_pop_i
);

  localparam int unsigned QD  = gcss_pkg::QUEUE_DEPTH;
  localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  gcss_pkg::cmd_t   q_mem_q [QD];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   fill_q, fill_d;

  gcss_pkg::cmd_t   cmd_new;
  logic             keep;
  logic             slot_ok;
  logic             push;
  logic             pop;

  // Writes to a slot past the table end are dropped here, as is opcode 3.
  assign slot_ok = (32'(entry_index_i) < TABLE_DEPTH);

  always_comb begin
    cmd_new.kind        = gcss_pkg::CMD_LOOKUP;
    cmd_new.slot        = entry_index_i;
    cmd_new.entry.first       = entry_first_glyph_i;
    cmd_new.entry.last        = entry_last_glyph_i;
    cmd_new.entry.start_index = entry_start_index_i;
    cmd_new.sub_value   = substitute_value_i;
    cmd_new.glyph       = lookup_glyph_i;
    keep                = 1'b0;
    case (opcode_i)
      gcss_pkg::OP_COV_WR: begin
        cmd_new.kind = gcss_pkg::CMD_COV_WR;
        keep         = slot_ok;
      end
      gcss_pkg::OP_SUB_WR: begin
        cmd_new.kind = gcss_pkg::CMD_SUB_WR;
        keep         = slot_ok;
      end
      gcss_pkg::OP_LOOKUP: begin
        cmd_new.kind = gcss_pkg::CMD_LOOKUP;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (fill_q != QCW'(QD));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o && keep;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gcss_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gcss_back #(
  parameter int unsigned TABLE_DEPTH = gcss_pkg::TABLE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gcss_pkg::cfg_t               cfg_i,
  input  wire logic                         cmd_valid_i,
  input  wire gcss_pkg::cmd_t               cmd_i,
  output logic                              cmd_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [gcss_pkg::GLYPH_W-1:0] result_glyph_o,
  output logic                              covered_o,
  output logic                              index_fault_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned GW  = gcss_pkg::GLYPH_W;
  localparam int unsigned IW  = gcss_pkg::CIDX_W;
  localparam int unsigned CEW = $bits(gcss_pkg::cov_entry_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_CHK   = 3'd2;
  localparam logic [2:0] ST_SUBRD = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [GW-1:0] glyph_q, glyph_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [GW-1:0] res_glyph_q, res_glyph_d;
  logic          res_cov_q, res_cov_d;
  logic          res_fault_q, res_fault_d;
  logic          out_valid_q, out_valid_d;
  logic [GW-1:0] out_glyph_q, out_glyph_d;
  logic          out_cov_q, out_cov_d;
  logic          out_fault_q, out_fault_d;

  logic [CW-1:0]        n_w;
  logic [CW-1:0]        cnt_nxt;
  logic                 cov_fmt_ok;
  logic                 sub_fmt_ok;
  logic                 hit;
  logic [IW-1:0]        idx_hit;
  logic                 fault;
  logic                 cov_we;
  logic                 sub_we;
  logic [AW-1:0]        cov_raddr;
  logic [CEW-1:0]       cov_rdata;
  logic [GW-1:0]        sub_rdata;
  gcss_pkg::cov_entry_t cov_ent;

  gcss_ram #(
    .WIDTH (CEW),
    .DEPTH (TABLE_DEPTH)
  ) u_cov_ram (
    .clk_i   (clk_i),
    .we_i    (cov_we),
    .waddr_i (AW'(cmd_i.slot)),
    .wdata_i (cmd_i.entry),
    .raddr_i (cov_raddr),
    .rdata_o (cov_rdata)
  );

  gcss_ram #(
    .WIDTH (GW),
    .DEPTH (TABLE_DEPTH)
  ) u_sub_ram (
    .clk_i   (clk_i),
    .we_i    (sub_we),
    .waddr_i (AW'(cmd_i.slot)),
    .wdata_i (cmd_i.sub_value),
    .raddr_i (AW'(idx_q)),
    .rdata_o (sub_rdata)
  );

  assign cov_ent = cov_rdata;

  // Entry count saturated to the table size.
  always_comb begin
    if (32'(cfg_i.cov_count) > TABLE_DEPTH) begin
      n_w = CW'(TABLE_DEPTH);
    end else begin
      n_w = CW'(cfg_i.cov_count);
    end
  end

  assign cov_fmt_ok = (cfg_i.cov_fmt == gcss_pkg::COV_FMT_LIST) ||
                      (cfg_i.cov_fmt == gcss_pkg::COV_FMT_RANGE);
  assign sub_fmt_ok = (cfg_i.sub_fmt == gcss_pkg::SUB_FMT_DELTA) ||
                      (cfg_i.sub_fmt == gcss_pkg::SUB_FMT_ARRAY);

  assign cnt_nxt   = cnt_q + 1'b1;
  // Entry cnt_q is on the read port now; fetch the next one.
  assign cov_raddr = (state_q == ST_SCAN) ? AW'(cnt_nxt) : '0;

  always_comb begin
    if (cfg_i.cov_fmt == gcss_pkg::COV_FMT_LIST) begin
      hit     = (cov_ent.first == glyph_q);
      idx_hit = IW'(cnt_q);
    end else begin
      hit     = (cov_ent.first <= glyph_q) && (glyph_q <= cov_ent.last);
      idx_hit = IW'(cov_ent.start_index) + IW'(glyph_q - cov_ent.first);
    end
  end

  assign fault = (idx_q >= IW'(cfg_i.sub_count)) || (32'(idx_q) >= TABLE_DEPTH);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    glyph_d     = glyph_q;
    idx_d       = idx_q;
    res_glyph_d = res_glyph_q;
    res_cov_d   = res_cov_q;
    res_fault_d = res_fault_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_glyph_d = out_glyph_q;
    out_cov_d   = out_cov_q;
    out_fault_d = out_fault_q;
    cov_we      = 1'b0;
    sub_we      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            gcss_pkg::CMD_COV_WR: begin
              cov_we = 1'b1;
            end
            gcss_pkg::CMD_SUB_WR: begin
              sub_we = 1'b1;
            end
            gcss_pkg::CMD_LOOKUP: begin
              glyph_d     = cmd_i.glyph;
              res_glyph_d = cmd_i.glyph;
              res_cov_d   = 1'b0;
              res_fault_d = 1'b0;
              cnt_d       = '0;
              n_d         = n_w;
              if (sub_fmt_ok && cov_fmt_ok && (n_w != '0)) begin
                state_d = ST_SCAN;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_cov_d = 1'b1;
          idx_d     = idx_hit;
          if (cfg_i.sub_fmt == gcss_pkg::SUB_FMT_DELTA) begin
            res_glyph_d = glyph_q + cfg_i.delta;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_CHK;
          end
        end else if (cnt_nxt == n_q) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_nxt;
        end
      end
      ST_CHK: begin
        // Substitute read at idx_q is issued in this cycle.
        if (fault) begin
          res_fault_d = 1'b1;
          state_d     = ST_DONE;
        end else begin
          state_d = ST_SUBRD;
        end
      end
      ST_SUBRD: begin
        res_glyph_d = sub_rdata;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_glyph_d = res_glyph_q;
          out_cov_d   = res_cov_q;
          out_fault_d = res_fault_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    n_q         <= n_d;
    glyph_q     <= glyph_d;
    idx_q       <= idx_d;
    res_glyph_q <= res_glyph_d;
    res_cov_q   <= res_cov_d;
    res_fault_q <= res_fault_d;
    out_glyph_q <= out_glyph_d;
    out_cov_q   <= out_cov_d;
    out_fault_q <= out_fault_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_glyph_o = out_glyph_q;
  assign covered_o      = out_cov_q;
  assign index_fault_o  = out_fault_q;

endmodule

`default_nettype wire

>>> rtl/glyph_coverage_single_substitution_top.sv
// Path from input acceptance to out_valid_o: a delta hit in slot k ends the search at slot k;
// when the substitute array is read, an index check comes before the read and an index fault
// skips it; a miss runs over the saturated coverage_count n; with no search the result goes
// straight to the output register. The back end runs one lookup at a time, does table writes
// while idle, and a stalled result holds the back end in its last state. Reset clears control
// state and sets the registers to their defaults; table contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module glyph_coverage_single_substitution_top #(
  parameter int unsigned TABLE_DEPTH = gcss_pkg::TABLE_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  // Configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [gcss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [gcss_pkg::CFG_DAT_W-1:0] cfg_wdata_i,

  // Input transactions
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic [gcss_pkg::SLOT_W-1:0]    entry_index_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0]   entry_first_glyph_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0]   entry_last_glyph_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0]   entry_start_index_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0]   substitute_value_i,
  input  wire logic [gcss_pkg::GLYPH_W-1:0]   lookup_glyph_i,

  // Result transactions
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [gcss_pkg::GLYPH_W-1:0]   result_glyph_o,
  output logic                                covered_o,
  output logic                                index_fault_o
);

  // Configuration registers; the user must write them only while the block is idle (the block
  // does not enforce this), so the back end reads them directly.
  gcss_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        gcss_pkg::CFG_COV_FMT:   cfg_d.cov_fmt   = cfg_wdata_i[gcss_pkg::FMT_W-1:0];
        gcss_pkg::CFG_COV_COUNT: cfg_d.cov_count = cfg_wdata_i[gcss_pkg::COUNT_W-1:0];
        gcss_pkg::CFG_SUB_FMT:   cfg_d.sub_fmt   = cfg_wdata_i[gcss_pkg::FMT_W-1:0];
        gcss_pkg::CFG_DELTA:     cfg_d.delta     = cfg_wdata_i[gcss_pkg::GLYPH_W-1:0];
        gcss_pkg::CFG_SUB_COUNT: cfg_d.sub_count = cfg_wdata_i[gcss_pkg::COUNT_W-1:0];
        default: begin
          cfg_d = cfg_q;   // unused index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cov_fmt   <= gcss_pkg::COV_FMT_LIST;
      cfg_q.cov_count <= '0;
      cfg_q.sub_fmt   <= gcss_pkg::SUB_FMT_DELTA;
      cfg_q.delta     <= '0;
      cfg_q.sub_count <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: takes transactions, drops the ones with no effect and queues
  // the rest as commands.
  logic           cmd_valid;
  logic           cmd_pop;
  gcss_pkg::cmd_t cmd;

  gcss_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .entry_index_i       (entry_index_i),
    .entry_first_glyph_i (entry_first_glyph_i),
    .entry_last_glyph_i  (entry_last_glyph_i),
    .entry_start_index_i (entry_start_index_i),
    .substitute_value_i  (substitute_value_i),
    .lookup_glyph_i      (lookup_glyph_i),
    .cmd_valid_o         (cmd_valid),
    .cmd_o               (cmd),
    .cmd_pop_i           (cmd_pop)
  );

  // Back end: owns both tables, runs the sequential coverage search and the
  // substitute read, and holds the result in an output register so the
  // next command can start while the result waits.
  gcss_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_glyph_o (result_glyph_o),
    .covered_o      (covered_o),
    .index_fault_o  (index_fault_o)
  );

  // A fault is only raised on a covered glyph.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!index_fault_o || covered_o))
    else $error("index fault on an uncovered glyph");

  // Delta substitution never consults the substitute count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cfg_q.sub_fmt == gcss_pkg::SUB_FMT_DELTA)) |-> !index_fault_o)
    else $error("index fault in delta substitution");

  // Input back-pressure only when the queue holds commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> cmd_valid)
    else $error("input stalled with an empty command queue");

  // A command is popped only when the queue holds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && !cmd_valid) |-> 1'b0)
    else $error("pop from an empty command queue");

endmodule

`default_nettype wire
